// File: sv/isotp_receive_reassembler_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ISO-TP receive reassembler
// Checks are compiled in unless SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ISOTP_RECEIVE_REASSEMBLER_TOP_MACROS_SVH
`define ISOTP_RECEIVE_REASSEMBLER_TOP_MACROS_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset
`define ISOTP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("isotp assertion failed");
// Check a property on every clock edge, reset included
`define ISOTP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("isotp assertion failed");
`else
`define ISOTP_ASSERT(lbl, clk, rstn, prop)
`define ISOTP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: sv/isotp_rr_pkg.sv
// ----------------------------------------------------------------------------
// ISO-TP receive reassembler package
// Shared result codes, constants, the job descriptor and the id reversal.
// ----------------------------------------------------------------------------
package isotp_rr_pkg;

  localparam int unsigned MaxFrameBytes = 8;
  localparam int unsigned IdW           = 29;
  localparam int unsigned CntW          = $clog2(MaxFrameBytes);
  localparam int unsigned PosW          = CntW + 1;

  // Result codes
  typedef enum logic [2:0] {
    KIND_SINGLE  = 3'd0,
    KIND_MULTI   = 3'd1,
    KIND_ABANDON = 3'd2,
    KIND_FLOW    = 3'd3,
    KIND_TIMEOUT = 3'd4
  } kind_e;

  // Flow-control status codes
  typedef enum logic [1:0] {
    FLOW_CONTINUE = 2'd0,
    FLOW_HOLD     = 2'd1,
    FLOW_ABORT    = 2'd2
  } flow_status_e;

  // Input commands
  localparam logic CmdFrame = 1'b0;
  localparam logic CmdTick  = 1'b1;

  // Configuration register indexes
  localparam logic CfgSessionId = 1'b0;
  localparam logic CfgTimeout   = 1'b1;

  // Protocol control codes (upper nibble of byte 0)
  localparam logic [3:0] PciSingle = 4'h0;
  localparam logic [3:0] PciFirst  = 4'h1;
  localparam logic [3:0] PciConsec = 4'h2;

  // Identifier reversal constants
  localparam logic [IdW-1:0] RevNearLo = 29'h7E0;
  localparam logic [IdW-1:0] RevFarLo  = 29'h7E8;
  localparam logic [IdW-1:0] RevEnd    = 29'h7F0;
  localparam logic [IdW-1:0] RevStep   = 29'h008;
  localparam logic [IdW-1:0] ExtBase   = 29'h18DA0000;

  // One frame's worth of results, expanded serially by the back end
  typedef struct packed {
    kind_e                             pay_kind;
    logic [MaxFrameBytes-1:0][7:0]     data;
    logic [CntW-1:0]                   first;
    logic [CntW-1:0]                   count;
    logic                              marker;
    logic                              msg_end;
    logic                              tail;
    kind_e                             tail_kind;
    logic [IdW-1:0]                    tail_id;
    flow_status_e                      tail_status;
  } job_t;

  // Reverse a diagnostic identifier; top bit flags a valid reverse
  function automatic logic [IdW:0] reverse_id(input logic [IdW-1:0] id);
    logic [IdW:0] res;
    res = '0;
    if (id >= RevNearLo && id < RevFarLo) begin
      res = {1'b1, id + RevStep};
    end else if (id >= RevFarLo && id < RevEnd) begin
      res = {1'b1, id - RevStep};
    end else if ((id & ExtBase) == ExtBase) begin
      res = {1'b1, ExtBase[IdW-1:16], id[7:0], id[15:8]};
    end
    return res;
  endfunction

endpackage

// File: sv/isotp_rr_front.sv
// ----------------------------------------------------------------------------
// ISO-TP reassembler front end
// Accepts items, classifies frames, keeps the session state and queues jobs.
// ----------------------------------------------------------------------------
`include "isotp_receive_reassembler_top_macros.svh"

module isotp_rr_front (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         in_valid_i,
  output logic                                         in_ready_o,
  input  logic                                         command_i,
  input  logic [isotp_rr_pkg::IdW-1:0]                 frame_id_i,
  input  logic [3:0]                                   frame_len_i,
  input  logic [isotp_rr_pkg::MaxFrameBytes-1:0][7:0]  frame_bytes_i,
  input  logic                                         cfg_valid_i,
  input  logic                                         cfg_index_i,
  input  logic [isotp_rr_pkg::IdW-1:0]                 cfg_data_i,
  input  logic                                         full_i,
  output logic                                         push_o,
  output isotp_rr_pkg::job_t                           job_o
);

  localparam int unsigned CntW = isotp_rr_pkg::CntW;

  logic [isotp_rr_pkg::IdW-1:0] session_q;
  logic [15:0]                  timeout_q;
  logic                         in_prog_q, in_prog_d;
  logic [3:0]                   seq_q, seq_d;
  logic [11:0]                  total_q, total_d;
  logic [12:0]                  br_q, br_d;
  logic [15:0]                  idle_q, idle_d;

  logic                         accept;
  logic [3:0]                   len_c;
  logic [3:0]                   code;
  logic [3:0]                   lo;
  logic [isotp_rr_pkg::IdW:0]   rev;
  logic [11:0]                  total_new;
  logic [12:0]                  br_new;
  logic [12:0]                  remaining;
  logic [3:0]                   avail;
  logic [15:0]                  idle_inc;
  logic                         done;
  logic [CntW-1:0]              take;
  isotp_rr_pkg::job_t           job;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Clamp the length and split out the control byte
  assign len_c     = (frame_len_i > 4'(isotp_rr_pkg::MaxFrameBytes)) ?
                     4'(isotp_rr_pkg::MaxFrameBytes) : frame_len_i;
  assign code      = frame_bytes_i[0][7:4];
  assign lo        = frame_bytes_i[0][3:0];
  assign rev       = isotp_rr_pkg::reverse_id(frame_id_i);
  assign total_new = {lo, frame_bytes_i[1]};
  assign br_new    = 13'(len_c) - 13'd2;
  assign remaining = {1'b0, total_q} - br_q;
  assign avail     = len_c - 4'd1;
  assign idle_inc  = (idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;

  // Classify the item, build its job and the next session state
  always_comb begin
    in_prog_d       = in_prog_q;
    seq_d           = seq_q;
    total_d         = total_q;
    br_d            = br_q;
    idle_d          = idle_q;
    done            = 1'b0;
    take            = '0;
    job             = '0;
    job.data        = frame_bytes_i;
    job.pay_kind    = isotp_rr_pkg::KIND_SINGLE;
    job.tail_kind   = isotp_rr_pkg::KIND_FLOW;
    job.tail_status = isotp_rr_pkg::FLOW_CONTINUE;
    if (command_i == isotp_rr_pkg::CmdTick) begin
      if (in_prog_q) begin
        idle_d = idle_inc;
        if (idle_inc >= timeout_q) begin
          in_prog_d     = 1'b0;
          idle_d        = '0;
          job.tail      = 1'b1;
          job.tail_kind = isotp_rr_pkg::KIND_TIMEOUT;
        end
      end
    end else if (frame_id_i == session_q && len_c != 4'd0) begin
      case (code)
        isotp_rr_pkg::PciSingle: begin
          if (len_c >= 4'd2 && {1'b0, len_c} >= {1'b0, lo} + 5'd1) begin
            if (lo == 4'd0) begin
              job.marker = 1'b1;
            end else begin
              job.count   = lo[CntW-1:0];
              job.first   = CntW'(1);
              job.msg_end = 1'b1;
            end
          end
        end
        isotp_rr_pkg::PciFirst: begin
          if (!in_prog_q) begin
            if (len_c < 4'd2) begin
              job.tail        = rev[isotp_rr_pkg::IdW];
              job.tail_id     = rev[isotp_rr_pkg::IdW-1:0];
              job.tail_status = isotp_rr_pkg::FLOW_ABORT;
            end else begin
              done         = br_new >= {1'b0, total_new};
              total_d      = total_new;
              br_d         = br_new;
              job.pay_kind = isotp_rr_pkg::KIND_MULTI;
              job.marker   = done && (len_c == 4'd2);
              job.count    = CntW'(len_c - 4'd2);
              job.first    = CntW'(2);
              job.msg_end  = done;
              if (!done) begin
                in_prog_d   = 1'b1;
                seq_d       = 4'd1;
                idle_d      = '0;
                job.tail    = rev[isotp_rr_pkg::IdW];
                job.tail_id = rev[isotp_rr_pkg::IdW-1:0];
              end
            end
          end
        end
        isotp_rr_pkg::PciConsec: begin
          if (in_prog_q && len_c >= 4'd2) begin
            if (lo != seq_q) begin
              in_prog_d     = 1'b0;
              job.tail      = 1'b1;
              job.tail_kind = isotp_rr_pkg::KIND_ABANDON;
            end else begin
              done         = remaining <= 13'(avail);
              take         = done ? remaining[CntW-1:0] : avail[CntW-1:0];
              seq_d        = seq_q + 4'd1;
              br_d         = br_q + 13'(take);
              idle_d       = '0;
              job.pay_kind = isotp_rr_pkg::KIND_MULTI;
              job.count    = take;
              job.first    = CntW'(1);
              job.msg_end  = done;
              if (done) begin
                in_prog_d = 1'b0;
              end
            end
          end
        end
        default: begin
          // flow-control and unknown codes: drop
        end
      endcase
    end
  end

  assign job_o  = job;
  assign push_o = accept && (job.marker || job.count != '0 || job.tail);

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      session_q <= 29'd2024;
      timeout_q <= 16'd1000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        isotp_rr_pkg::CfgSessionId: session_q <= cfg_data_i;
        isotp_rr_pkg::CfgTimeout:   timeout_q <= cfg_data_i[15:0];
      endcase
    end
  end

  // Advance session state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_prog_q <= 1'b0;
      seq_q     <= 4'd1;
      total_q   <= '0;
      br_q      <= '0;
      idle_q    <= '0;
    end else if (accept) begin
      in_prog_q <= in_prog_d;
      seq_q     <= seq_d;
      total_q   <= total_d;
      br_q      <= br_d;
      idle_q    <= idle_d;
    end
  end

  `ISOTP_ASSERT(a_session_open, clk_i, rst_ni, in_prog_q |-> (br_q < {1'b0, total_q}))

endmodule

// File: sv/isotp_rr_queue.sv
// ----------------------------------------------------------------------------
// ISO-TP reassembler job queue
// Short FIFO of job descriptors between the front and back ends.
// ----------------------------------------------------------------------------
`include "isotp_receive_reassembler_top_macros.svh"

module isotp_rr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  isotp_rr_pkg::job_t push_job_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output isotp_rr_pkg::job_t job_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  isotp_rr_pkg::job_t mem_q [DEPTH];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    count_q;
  logic               do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (!push_i && do_pop) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  `ISOTP_ASSERT(a_fill_bound, clk_i, rst_ni, count_q <= CntW'(DEPTH))
  `ISOTP_ASSERT(a_no_overrun, clk_i, rst_ni, push_i |-> (count_q < CntW'(DEPTH)))

endmodule

// File: sv/isotp_rr_back.sv
// ----------------------------------------------------------------------------
// ISO-TP reassembler back end
// Expands one job into registered result items, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "isotp_receive_reassembler_top_macros.svh"

module isotp_rr_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  isotp_rr_pkg::job_t           q_job_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   kind_o,
  output logic [7:0]                   data_byte_o,
  output logic                         byte_valid_o,
  output logic                         msg_last_o,
  output logic                         run_last_o,
  output logic [isotp_rr_pkg::IdW-1:0] flow_id_o,
  output logic [1:0]                   flow_status_o
);

  localparam int unsigned CntW = isotp_rr_pkg::CntW;
  localparam int unsigned PosW = isotp_rr_pkg::PosW;

  isotp_rr_pkg::job_t           job_q;
  logic                         busy_q;
  logic [PosW-1:0]              pos_q;
  logic                         out_valid_q;
  isotp_rr_pkg::kind_e          kind_q;
  logic [7:0]                   data_q;
  logic                         bvalid_q;
  logic                         mlast_q;
  logic                         rlast_q;
  logic [isotp_rr_pkg::IdW-1:0] fid_q;
  isotp_rr_pkg::flow_status_e   fstat_q;

  logic [PosW-1:0]              run_len;
  logic [PosW-1:0]              b;
  logic [CntW-1:0]              idx;
  logic                         is_marker;
  logic                         is_pay;
  logic                         is_last;
  logic                         adv;
  isotp_rr_pkg::kind_e          r_kind;
  logic [7:0]                   r_data;
  logic                         r_mlast;
  logic [isotp_rr_pkg::IdW-1:0] r_fid;
  isotp_rr_pkg::flow_status_e   r_fstat;

  assign q_pop_o = !busy_q && q_valid_i;
  assign adv     = busy_q && (!out_valid_q || out_ready_i);
  assign run_len = PosW'(job_q.marker) + PosW'(job_q.count) + PosW'(job_q.tail);

  // Pick the result at the current position of the job
  assign b         = pos_q - PosW'(job_q.marker);
  assign idx       = job_q.first + b[CntW-1:0];
  assign is_marker = job_q.marker && (pos_q == '0);
  assign is_pay    = !is_marker && (b < PosW'(job_q.count));
  assign is_last   = (pos_q == run_len - PosW'(1));

  always_comb begin
    r_kind  = job_q.tail_kind;
    r_data  = '0;
    r_mlast = 1'b0;
    r_fid   = job_q.tail_id;
    r_fstat = job_q.tail_status;
    if (is_marker) begin
      r_kind  = job_q.pay_kind;
      r_mlast = 1'b1;
      r_fid   = '0;
      r_fstat = isotp_rr_pkg::FLOW_CONTINUE;
    end else if (is_pay) begin
      r_kind  = job_q.pay_kind;
      r_data  = job_q.data[idx];
      r_mlast = job_q.msg_end && (b == PosW'(job_q.count) - PosW'(1));
      r_fid   = '0;
      r_fstat = isotp_rr_pkg::FLOW_CONTINUE;
    end
  end

  // Take a job and step through its results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        busy_q <= 1'b1;
        pos_q  <= '0;
      end else if (adv) begin
        pos_q <= pos_q + PosW'(1);
        if (is_last) begin
          busy_q <= 1'b0;
        end
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the job and the output payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= q_job_i;
    end
    if (adv) begin
      kind_q   <= r_kind;
      data_q   <= r_data;
      bvalid_q <= is_pay;
      mlast_q  <= r_mlast;
      rlast_q  <= is_last;
      fid_q    <= r_fid;
      fstat_q  <= r_fstat;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign data_byte_o   = data_q;
  assign byte_valid_o  = bvalid_q;
  assign msg_last_o    = mlast_q;
  assign run_last_o    = rlast_q;
  assign flow_id_o     = fid_q;
  assign flow_status_o = fstat_q;

  `ISOTP_ASSERT(a_pos_in_run, clk_i, rst_ni, busy_q |-> (pos_q < run_len))

endmodule

// File: sv/isotp_receive_reassembler_top.sv
// ----------------------------------------------------------------------------
// ISO-TP receive reassembler, top level
// Reassembles single, first and consecutive frames of one session into a
// stream of payload bytes and answers with flow-control, abandon and timeout results.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_ready_o  command, frame_id, frame_len, byte_0..7
// out       output     out_valid_o/out_ready_i kind, data_byte, byte_valid, msg_last,
//                                              run_last, flow_id, flow_status
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// The front end takes one item per cycle while the job queue has room.
// The back end sends one result per cycle while the output is not stalled; it
// pops an item's job, steps through its results and takes no new job until the
// last result is registered. Items that cause no result leave no job.
// Reset clears the session and the queue; configuration resets to 2024/1000.
// A stalled output holds the back end; a full queue deasserts in_ready_o.
// ----------------------------------------------------------------------------
module isotp_receive_reassembler_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [28:0] frame_id_i,
  input  logic [3:0]  frame_len_i,
  input  logic [7:0]  byte_0_i,
  input  logic [7:0]  byte_1_i,
  input  logic [7:0]  byte_2_i,
  input  logic [7:0]  byte_3_i,
  input  logic [7:0]  byte_4_i,
  input  logic [7:0]  byte_5_i,
  input  logic [7:0]  byte_6_i,
  input  logic [7:0]  byte_7_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic        byte_valid_o,
  output logic        msg_last_o,
  output logic        run_last_o,
  output logic [28:0] flow_id_o,
  output logic [1:0]  flow_status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [28:0] cfg_data_i
);

  logic [isotp_rr_pkg::MaxFrameBytes-1:0][7:0] frame_bytes;
  logic                                        push;
  logic                                        full;
  logic                                        pop;
  logic                                        q_valid;
  isotp_rr_pkg::job_t                          push_job;
  isotp_rr_pkg::job_t                          q_job;

  assign cfg_ready_o = 1'b1;
  assign frame_bytes = {byte_7_i, byte_6_i, byte_5_i, byte_4_i,
                        byte_3_i, byte_2_i, byte_1_i, byte_0_i};

  // Classify items and keep session state
  isotp_rr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .frame_id_i    (frame_id_i),
    .frame_len_i   (frame_len_i),
    .frame_bytes_i (frame_bytes),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .full_i        (full),
    .push_o        (push),
    .job_o         (push_job)
  );

  // Buffer jobs between the two ends
  isotp_rr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .job_o      (q_job)
  );

  // Expand jobs into result items
  isotp_rr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_job_i       (q_job),
    .q_pop_o       (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .data_byte_o   (data_byte_o),
    .byte_valid_o  (byte_valid_o),
    .msg_last_o    (msg_last_o),
    .run_last_o    (run_last_o),
    .flow_id_o     (flow_id_o),
    .flow_status_o (flow_status_o)
  );

endmodule
